FILE: hw/rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; every other file in hw/rtl imports this package.
package u16u8_pkg;

    // Request codes
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Byte-slot count of one job (largest output burst of one item)
    localparam int MAX_BYTES  = 6;
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);
    localparam int IDX_W      = $clog2(MAX_BYTES);

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Surrogate and range constants
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;   // 0xDC00..0xDFFF
    localparam logic [15:0] ONE_BYTE_MAX  = 16'h007f;
    localparam logic [15:0] TWO_BYTE_MAX  = 16'h07ff;
    localparam logic [20:0] SUPPL_BASE    = 21'h10000;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic        req_type;
        logic [15:0] code_unit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // One classified item: bytes in slot order (slot 0 goes first)
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } job_t;

    // Three-byte form of a 16-bit unit, slot 0 first
    function automatic logic [2:0][7:0] three_bytes(input logic [15:0] u);
        logic [2:0][7:0] b;
        b[0] = LEAD3 | {4'h0, u[15:12]};
        b[1] = CONT  | {2'b00, u[11:6]};
        b[2] = CONT  | {2'b00, u[5:0]};
        return b;
    endfunction

endpackage

FILE: hw/rtl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue, serializer.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.

// One UTF-16 code unit enters per transfer on the push side; the pop side
// delivers its UTF-8 bytes one per cycle while pop is held high, last_byte
// marking the final byte caused by each item. An item yields 1 to 6 bytes
// (a held high surrogate or an empty finish yields none), so ASCII text
// flows at one item per cycle while pop is held high, and three-byte text
// at one item per three output bytes. The single-byte output register sets
// the rate; a two-entry job queue lets input be accepted while bytes of
// earlier items are still waiting. The first byte passes through the job queue and then the output register.
module utf16_to_utf8_encoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  u16u8_pkg::in_item_t   in_item,
    output logic                  empty,
    input  logic                  pop,
    output u16u8_pkg::out_item_t  out_item
);
    import u16u8_pkg::*;

    logic push_fire;
    job_t new_job;
    logic new_job_valid;
    job_t head_job;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign full      = q_full;
    assign push_fire = push && !q_full;

    // Classify incoming units
    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_fire (push_fire),
        .in_item   (in_item),
        .job       (new_job),
        .job_valid (new_job_valid)
    );

    // Decouple front and back
    u16u8_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (new_job_valid),
        .wr_job  (new_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // Serialize bytes
    u16u8_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

`ifndef NO_ASSERTIONS
    // Every queued job carries between one and six bytes
    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        new_job_valid |-> (new_job.count != '0 && new_job.count <= CNT_W'(MAX_BYTES)))
        else $error("job with invalid byte count");

    // Never read an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue underflow");

    // A byte that is not the last of its item is always followed by another
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.last_byte) |=> !empty)
        else $error("byte burst broken before last byte");
`endif

endmodule

FILE: hw/rtl/u16u8_front.sv
// Front end: accepts code units, tracks the held high surrogate and
// classifies each item into a job of UTF-8 bytes. Depends on u16u8_pkg.
module u16u8_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_fire,
    input  u16u8_pkg::in_item_t   in_item,
    output u16u8_pkg::job_t       job,
    output logic                  job_valid
);
    import u16u8_pkg::*;

    logic [15:0]     pending_reg;
    logic [15:0]     pending_next;
    logic            has_pend;
    logic            is_high;
    logic            is_low;
    logic [15:0]     u;
    logic [20:0]     scalar;
    logic [2:0][7:0] flush_bytes;
    logic [2:0][7:0] unit_bytes;
    logic [2:0][7:0] unit_three;
    logic [1:0]      unit_cnt;
    job_t            job_c;

    assign u        = in_item.code_unit;
    assign has_pend = (pending_reg != 16'h0000);
    assign is_high  = (u[15:10] == HIGH_SURR_TAG);
    assign is_low   = (u[15:10] == LOW_SURR_TAG);

    // Combine a surrogate pair into a supplementary scalar
    assign scalar      = {1'b0, pending_reg[9:0], u[9:0]} + SUPPL_BASE;
    assign flush_bytes = three_bytes(pending_reg);
    assign unit_three  = three_bytes(u);

    // Encode the unit on its own
    always_comb
    begin
        unit_bytes = '0;
        unit_cnt   = 2'd0;
        if (u <= ONE_BYTE_MAX)
        begin
            unit_bytes[0] = u[7:0];
            unit_cnt      = 2'd1;
        end
        else if (u <= TWO_BYTE_MAX)
        begin
            unit_bytes[0] = LEAD2 | {3'b000, u[10:6]};
            unit_bytes[1] = CONT  | {2'b00, u[5:0]};
            unit_cnt      = 2'd2;
        end
        else if (!is_high)
        begin
            unit_bytes = unit_three;
            unit_cnt   = 2'd3;
        end
    end

    // Classify the item and build its job
    always_comb
    begin
        job_c        = '0;
        pending_next = pending_reg;
        if (in_item.req_type == REQ_FINISH)
        begin
            if (has_pend)
            begin
                job_c.bytes[2:0] = flush_bytes;
                job_c.count      = CNT_W'(3);
                pending_next     = 16'h0000;
            end
        end
        else if (has_pend && is_low)
        begin
            job_c.bytes[0] = LEAD4 | {5'b00000, scalar[20:18]};
            job_c.bytes[1] = CONT  | {2'b00, scalar[17:12]};
            job_c.bytes[2] = CONT  | {2'b00, scalar[11:6]};
            job_c.bytes[3] = CONT  | {2'b00, scalar[5:0]};
            job_c.count    = CNT_W'(4);
            pending_next   = 16'h0000;
        end
        else
        begin
            if (has_pend)
            begin
                job_c.bytes[2:0] = flush_bytes;
                job_c.bytes[5:3] = unit_bytes;
                job_c.count      = CNT_W'(3) + CNT_W'(unit_cnt);
            end
            else
            begin
                job_c.bytes[2:0] = unit_bytes;
                job_c.count      = CNT_W'(unit_cnt);
            end
            pending_next = is_high ? u : 16'h0000;
        end
    end

    // Hold the pending high surrogate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 16'h0000;
        else if (push_fire)
            pending_reg <= pending_next;
    end

    assign job       = job_c;
    assign job_valid = push_fire && (job_c.count != '0);

endmodule

FILE: hw/rtl/u16u8_queue.sv
// Short job queue between the front end and the byte serializer.
// Depends on u16u8_pkg for the job type and depth constants.
module u16u8_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  u16u8_pkg::job_t   wr_job,
    input  logic              rd_en,
    output u16u8_pkg::job_t   rd_job,
    output logic              q_empty,
    output logic              q_full
);
    import u16u8_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_job  = slot_reg[rd_ptr_reg];

    // Store written jobs
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: hw/rtl/u16u8_back.sv
// Back end: serializes queued jobs into one UTF-8 byte per cycle, unless the
// receiver holds pop low, through a registered output stage. Depends on u16u8_pkg.
module u16u8_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u16u8_pkg::job_t       head_job,
    input  logic                  q_empty,
    output logic                  q_pop,
    output u16u8_pkg::out_item_t  out_item,
    output logic                  empty,
    input  logic                  pop
);
    import u16u8_pkg::*;

    job_t             job_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    job_t             cur_job;
    logic [IDX_W-1:0] cur_idx;
    logic             cur_valid;
    logic             cur_last;
    logic             advance;

    // Pick the byte source: job in progress, else queue head
    assign cur_valid = busy_reg || !q_empty;
    assign cur_job   = busy_reg ? job_reg : head_job;
    assign cur_idx   = busy_reg ? idx_reg : '0;
    assign cur_last  = (CNT_W'(cur_idx) + CNT_W'(1)) == cur_job.count;
    assign advance   = !out_valid_reg || pop;
    assign q_pop     = advance && !busy_reg && !q_empty;

    // Track the job in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (advance && cur_valid)
        begin
            busy_reg <= !cur_last;
            idx_reg  <= cur_idx + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= head_job;
    end

    // Hold the output byte until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= cur_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && cur_valid)
        begin
            out_reg.out_byte  <= cur_job.bytes[cur_idx];
            out_reg.last_byte <= cur_last;
        end
    end

    assign out_item = out_reg;
    assign empty    = !out_valid_reg;

endmodule

FILE: verif/utf16_to_utf8_encoder_tb.sv
// Self-checking testbench for utf16_to_utf8_encoder: UTF-16 units in, UTF-8 bytes out.
// Depends on u16u8_pkg and the encoder RTL; keeps its own model of the surrogate hold.
module utf16_to_utf8_encoder_tb;
    import u16u8_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_TIME   = 4_000_000;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    in_item_t  in_item = '0;
    logic      full;
    logic      empty;
    out_item_t out_item;

    // Model state and bytes still owed by the encoder
    logic [15:0] held_high = '0;
    out_item_t   utf8_due_q [$];
    int          fail_count = 0;

    // Idle rates and the long receiver hold-off
    int tx_idle_pct      = 0;
    int rx_idle_pct      = 0;
    int pop_hold_request = 0;
    int pop_hold_left    = 0;

    utf16_to_utf8_encoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Build the three-byte form of a 16-bit unit, first byte in the top bits
    function automatic logic [23:0] lead3_form(input logic [15:0] u);
        return {LEAD3 | {4'h0, u[15:12]}, CONT | {2'b00, u[11:6]}, CONT | {2'b00, u[5:0]}};
    endfunction

    // Work out the bytes one accepted item causes and queue them
    function automatic void predict_utf8(input in_item_t it);
        logic [7:0]  seq [$];
        logic [23:0] tri_bytes;
        logic [20:0] scalar;
        logic [15:0] u;
        out_item_t   b;
        u = it.code_unit;
        if (it.req_type == REQ_FINISH)
        begin
            if (held_high != '0)
            begin
                tri_bytes = lead3_form(held_high);
                seq.push_back(tri_bytes[23:16]);
                seq.push_back(tri_bytes[15:8]);
                seq.push_back(tri_bytes[7:0]);
                held_high = '0;
            end
        end
        else if (held_high != '0 && u[15:10] == LOW_SURR_TAG)
        begin
            // Join the pair into one supplementary code point
            scalar = {1'b0, held_high[9:0], u[9:0]} + SUPPL_BASE;
            seq.push_back(LEAD4 | {5'b0, scalar[20:18]});
            seq.push_back(CONT | {2'b00, scalar[17:12]});
            seq.push_back(CONT | {2'b00, scalar[11:6]});
            seq.push_back(CONT | {2'b00, scalar[5:0]});
            held_high = '0;
        end
        else
        begin
            // Flush a held unit that found no partner
            if (held_high != '0)
            begin
                tri_bytes = lead3_form(held_high);
                seq.push_back(tri_bytes[23:16]);
                seq.push_back(tri_bytes[15:8]);
                seq.push_back(tri_bytes[7:0]);
                held_high = '0;
            end
            if (u <= ONE_BYTE_MAX)
                seq.push_back(u[7:0]);
            else if (u <= TWO_BYTE_MAX)
            begin
                seq.push_back(LEAD2 | {3'b000, u[10:6]});
                seq.push_back(CONT | {2'b00, u[5:0]});
            end
            else if (u[15:10] == HIGH_SURR_TAG)
                held_high = u;
            else
            begin
                tri_bytes = lead3_form(u);
                seq.push_back(tri_bytes[23:16]);
                seq.push_back(tri_bytes[15:8]);
                seq.push_back(tri_bytes[7:0]);
            end
        end
        foreach (seq[i])
        begin
            b.out_byte  = seq[i];
            b.last_byte = (i == seq.size() - 1);
            utf8_due_q.push_back(b);
        end
    endfunction

    // Drive pop: honor a long hold-off first, else idle at the current rate
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold_request > 0)
        begin
            pop_hold_left = pop_hold_request - 1;
            pop_hold_request = 0;
            pop <= 1'b0;
        end
        else if (pop_hold_left > 0)
        begin
            pop_hold_left = pop_hold_left - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every byte transfer against the oldest owed byte
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (utf8_due_q.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got %h/%b",
                         $time, out_item.out_byte, out_item.last_byte);
                fail_count++;
            end
            else
            begin
                want = utf8_due_q.pop_front();
                if (out_item.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte mismatch: expected %h, got %h",
                             $time, want.out_byte, out_item.out_byte);
                    fail_count++;
                end
                if (out_item.last_byte !== want.last_byte)
                begin
                    $display("%0t: last_byte mismatch: expected %b, got %b",
                             $time, want.last_byte, out_item.last_byte);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item and hold it until the transfer; push stays high afterward
    task automatic push_unit(input logic rt, input logic [15:0] cu);
        in_item_t it;
        it.req_type  = rt;
        it.code_unit = cu;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_utf8(it);
    endtask

    // Drop push and wait until every owed byte has come out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (utf8_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Range edges of the one, two and three byte forms
    task automatic test_boundaries();
        push_unit(REQ_ENCODE, 16'h0000);
        push_unit(REQ_ENCODE, 16'h007f);
        push_unit(REQ_ENCODE, 16'h0080);
        push_unit(REQ_ENCODE, 16'h07ff);
        push_unit(REQ_ENCODE, 16'h0800);
        push_unit(REQ_ENCODE, 16'hd7ff);
        push_unit(REQ_ENCODE, 16'he000);
        push_unit(REQ_ENCODE, 16'hffff);
    endtask

    // Pairs, lone halves, chained high halves and finish handling
    task automatic test_surrogates();
        push_unit(REQ_FINISH, 16'hffff);
        push_unit(REQ_ENCODE, 16'hd800);
        push_unit(REQ_ENCODE, 16'hdc00);
        push_unit(REQ_ENCODE, 16'hdbff);
        push_unit(REQ_ENCODE, 16'hdfff);
        push_unit(REQ_ENCODE, 16'hdc00);
        push_unit(REQ_ENCODE, 16'hd801);
        push_unit(REQ_ENCODE, 16'h0041);
        push_unit(REQ_ENCODE, 16'hda00);
        push_unit(REQ_ENCODE, 16'hdb00);
        push_unit(REQ_ENCODE, 16'hdc55);
        push_unit(REQ_ENCODE, 16'hd9ab);
        push_unit(REQ_ENCODE, 16'h05a5);
        push_unit(REQ_ENCODE, 16'hdbfe);
        push_unit(REQ_ENCODE, 16'hfffe);
        push_unit(REQ_ENCODE, 16'hd83d);
        push_unit(REQ_FINISH, 16'h0000);
    endtask

    // Mostly well-formed text with random content, some broken sequences
    task automatic test_random_mix(input int n_items);
        int          sent;
        int          pick;
        logic [15:0] u;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                push_unit(REQ_ENCODE, 16'hd800 | 16'($urandom_range(16'h03ff)));
                push_unit(REQ_ENCODE, 16'hdc00 | 16'($urandom_range(16'h03ff)));
                sent += 2;
            end
            else if (pick < 45)
            begin
                push_unit(REQ_ENCODE, 16'($urandom_range(16'h007f)));
                sent += 1;
            end
            else if (pick < 57)
            begin
                push_unit(REQ_ENCODE, 16'($urandom_range(16'h07ff, 16'h0080)));
                sent += 1;
            end
            else if (pick < 70)
            begin
                if ($urandom_range(1))
                    u = 16'($urandom_range(16'hd7ff, 16'h0800));
                else
                    u = 16'($urandom_range(16'hffff, 16'he000));
                push_unit(REQ_ENCODE, u);
                sent += 1;
            end
            else if (pick < 76)
            begin
                push_unit(REQ_ENCODE, 16'hdc00 | 16'($urandom_range(16'h03ff)));
                sent += 1;
            end
            else if (pick < 84)
            begin
                // High half followed by anything that is not a low half
                u = 16'($urandom);
                while (u[15:10] == LOW_SURR_TAG)
                    u = 16'($urandom);
                push_unit(REQ_ENCODE, 16'hd800 | 16'($urandom_range(16'h03ff)));
                push_unit(REQ_ENCODE, u);
                sent += 2;
            end
            else if (pick < 90)
            begin
                if ($urandom_range(1))
                begin
                    push_unit(REQ_ENCODE, 16'hd800 | 16'($urandom_range(16'h03ff)));
                    sent += 1;
                end
                push_unit(REQ_FINISH, 16'($urandom));
                sent += 1;
            end
            else
            begin
                push_unit(REQ_ENCODE, 16'($urandom));
                sent += 1;
            end
        end
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_backpressure();
        int saved_tx;
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        pop_hold_request = 80;
        test_random_mix(20);
        tx_idle_pct = saved_tx;
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 72;
        test_boundaries();
        test_surrogates();
        wait_drained();
        test_random_mix(25);
        test_backpressure();

        tx_idle_pct = 72;
        rx_idle_pct = 27;
        test_random_mix(30);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_mix(25);
        wait_drained();

        if (utf8_due_q.size() != 0)
        begin
            $display("%0t: %0d bytes never arrived", $time, utf8_due_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("utf16_to_utf8_encoder_tb passed");
        else
            $display("utf16_to_utf8_encoder_tb failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(LIMIT_TIME);
        $display("utf16_to_utf8_encoder_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_encoder.sv
verif/utf16_to_utf8_encoder_tb.sv
